[rtl/ectg_pkg.sv]
// Shared types, widths and arctangent table for the ECEF to latitude/longitude block.
package ectg_pkg;

   localparam int POS_W      = 28;
   localparam int LAT_W      = 28;
   localparam int LON_W      = 29;
   localparam int OPD_W      = 33;
   localparam int DP_W       = 64;
   localparam int ANG_W      = 46;
   localparam int ANG_FRAC   = 16;
   localparam int RND_W      = ANG_W - ANG_FRAC;
   localparam int PRE_SHIFT  = 28;
   localparam int SQ_W       = 55;
   localparam int SHIFT_W    = 5;
   localparam int SQRT_STEPS = 32;
   localparam int QBITS      = 60;

   localparam logic [63:0] FULL45 = 64'd45000000 << ANG_FRAC;

   localparam logic signed [RND_W-1:0] LAT_LIM = RND_W'(90000000);
   localparam logic signed [RND_W-1:0] LON_LIM = RND_W'(180000000);

   typedef struct packed {
      logic zero;
      logic xy_zero;
   } vec_flags_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      vec_flags_type           flags;
   } sqrt_side_type;

   // shift-subtract quotient, elaboration use only
   function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] r;
      logic [63:0] q;
      r = '0;
      q = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], n[b]};
         if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(2^-i) in Q60, i >= 1
   function automatic logic [63:0] atan_pow2(input int i);
      logic [63:0] sum;
      logic [63:0] term;
      logic        done;
      int          sh;
      sum  = '0;
      done = 1'b0;
      for (int k = 0; k < 64; k++) begin
         sh = i * (2 * k + 1);
         if (sh >= QBITS) done = 1'b1;
         if (!done) begin
            term = udiv(64'd1 << (QBITS - sh), 64'(2 * k + 1));
            if (k[0]) sum = sum - term;
            else sum = sum + term;
         end
      end
      return sum;
   endfunction

   // atan(1/3) in Q60
   function automatic logic [63:0] atan_third();
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] p;
      logic        done;
      sum  = '0;
      p    = 64'd3;
      done = 1'b0;
      for (int k = 0; k < 40; k++) begin
         if (p > (64'd1 << QBITS)) done = 1'b1;
         if (!done) begin
            term = udiv(udiv(64'd1 << QBITS, p), 64'(2 * k + 1));
            if (k[0]) sum = sum - term;
            else sum = sum + term;
            p = p * 64'd9;
         end
      end
      return sum;
   endfunction

   function automatic logic [63:0] mul_div(input logic [63:0] x, input logic [63:0] m,
                                           input logic [63:0] d);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         q = q << 1;
         r = r << 1;
         if (r >= d) begin
            r = r - d;
            q = q + 64'd1;
         end
         if (m[b]) begin
            r = r + x;
            if (r >= d) begin
               r = r - d;
               q = q + 64'd1;
            end
         end
      end
      return q;
   endfunction

   // arctangent table entry i, in 2^-16 microdegree
   function automatic logic [63:0] atan_entry(input int i);
      logic [63:0] quarter;
      quarter = atan_pow2(1) + atan_third();
      if (i == 0) return FULL45;
      return mul_div(atan_pow2(i), FULL45, quarter);
   endfunction

endpackage

[rtl/ectg_norm.sv]
// Input register, common normalizing shift and squared horizontal radius.
module ectg_norm
   import ectg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [POS_W-1:0] in_x,
   input  logic signed [POS_W-1:0] in_y,
   input  logic signed [POS_W-1:0] in_z,
   output logic                    out_valid,
   output logic [DP_W-1:0]         out_s2,
   output sqrt_side_type           out_side
);

   logic [4:0] v_ff;

   logic signed [POS_W-1:0] x1_ff, y1_ff, z1_ff;
   logic signed [POS_W-1:0] x2_ff, y2_ff, z2_ff;
   logic signed [POS_W-1:0] x3_ff, y3_ff, z3_ff;
   logic signed [POS_W-1:0] x4_ff, y4_ff, z4_ff;
   logic [SHIFT_W-1:0]      sh_ff;
   logic [SHIFT_W-1:0]      sh_in;
   vec_flags_type           f2_ff, f3_ff, f4_ff;
   vec_flags_type           f2_in;
   logic [SQ_W-1:0]         xx_ff, yy_ff;
   logic signed [2*POS_W-1:0] xx_in, yy_in;
   logic [SQ_W:0]           sum_in;
   logic [DP_W-1:0]         s2_ff;
   sqrt_side_type           side_ff;

   logic [POS_W-1:0] ax, ay, az, m;

   always_comb begin
      ax = POS_W'(x1_ff[POS_W-1] ? -x1_ff : x1_ff);
      ay = POS_W'(y1_ff[POS_W-1] ? -y1_ff : y1_ff);
      az = POS_W'(z1_ff[POS_W-1] ? -z1_ff : z1_ff);
      m  = ax;
      if (ay > m) m = ay;
      if (az > m) m = az;
      sh_in = '0;
      for (int b = 0; b < POS_W - 2; b++) begin
         if (m[b]) sh_in = SHIFT_W'(POS_W - 2 - b);
      end
      if (m[POS_W-1:POS_W-2] != 2'b00) sh_in = '0;
      f2_in.xy_zero = (x1_ff == '0) && (y1_ff == '0);
      f2_in.zero    = f2_in.xy_zero && (z1_ff == '0);
   end

   assign xx_in  = x3_ff * x3_ff;
   assign yy_in  = y3_ff * y3_ff;
   assign sum_in = {1'b0, xx_ff} + {1'b0, yy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= in_x;
         y1_ff <= in_y;
         z1_ff <= in_z;
         x2_ff <= x1_ff;
         y2_ff <= y1_ff;
         z2_ff <= z1_ff;
         sh_ff <= sh_in;
         f2_ff <= f2_in;
         x3_ff <= x2_ff <<< sh_ff;
         y3_ff <= y2_ff <<< sh_ff;
         z3_ff <= z2_ff <<< sh_ff;
         f3_ff <= f2_ff;
         xx_ff <= xx_in[SQ_W-1:0];
         yy_ff <= yy_in[SQ_W-1:0];
         x4_ff <= x3_ff;
         y4_ff <= y3_ff;
         z4_ff <= z3_ff;
         f4_ff <= f3_ff;
         s2_ff <= {sum_in[DP_W-9:0], 8'd0};
         side_ff.x     <= x4_ff;
         side_ff.y     <= y4_ff;
         side_ff.z     <= z4_ff;
         side_ff.flags <= f4_ff;
      end
   end

   assign out_valid = v_ff[4];
   assign out_s2    = s2_ff;
   assign out_side  = side_ff;

endmodule

[rtl/ectg_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module ectg_sqrt
   import ectg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [DP_W-1:0]   in_val,
   input  sqrt_side_type     in_side,
   output logic              out_valid,
   output logic [OPD_W-2:0]  out_root,
   output sqrt_side_type     out_side
);

   logic [DP_W-1:0] rem_w  [0:SQRT_STEPS];
   logic [DP_W-1:0] res_w  [0:SQRT_STEPS];
   logic            v_w    [0:SQRT_STEPS];
   sqrt_side_type   side_w [0:SQRT_STEPS];

   assign rem_w[0]  = in_val;
   assign res_w[0]  = '0;
   assign v_w[0]    = in_valid;
   assign side_w[0] = in_side;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [DP_W-1:0] BIT = 64'd1 << (DP_W - 2 - 2 * k);
      logic [DP_W-1:0] rem_ff, res_ff, trial;
      logic            v_ff;
      sqrt_side_type   side_ff;

      assign trial = res_w[k] + BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en) begin
            v_ff <= v_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff <= side_w[k];
            if (rem_w[k] >= trial) begin
               rem_ff <= rem_w[k] - trial;
               res_ff <= (res_w[k] >> 1) + BIT;
            end else begin
               rem_ff <= rem_w[k];
               res_ff <= res_w[k] >> 1;
            end
         end
      end

      assign rem_w[k+1]  = rem_ff;
      assign res_w[k+1]  = res_ff;
      assign v_w[k+1]    = v_ff;
      assign side_w[k+1] = side_ff;
   end

   assign out_valid = v_w[SQRT_STEPS];
   assign out_root  = res_w[SQRT_STEPS][OPD_W-2:0];
   assign out_side  = side_w[SQRT_STEPS];

endmodule

[rtl/ectg_cordic.sv]
// Pipelined vectoring CORDIC giving atan2 in 2^-16 microdegree.
module ectg_cordic
   import ectg_pkg::*;
#(
   parameter int STEPS = 32
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [OPD_W-1:0] in_x,
   input  logic signed [OPD_W-1:0] in_y,
   input  logic                    in_tag,
   output logic                    out_valid,
   output logic signed [ANG_W-1:0] out_angle,
   output logic                    out_tag
);

   localparam logic signed [ANG_W-1:0] RIGHT = ANG_W'(2 * FULL45);

   logic signed [DP_W-1:0]  cx_w [0:STEPS];
   logic signed [DP_W-1:0]  cy_w [0:STEPS];
   logic signed [ANG_W-1:0] ca_w [0:STEPS];
   logic                    cv_w [0:STEPS];
   logic                    ct_w [0:STEPS];

   logic signed [DP_W-1:0]  px, py, px_in, py_in;
   logic signed [ANG_W-1:0] pa_in;
   logic signed [DP_W-1:0]  px_ff, py_ff;
   logic signed [ANG_W-1:0] pa_ff;
   logic                    pv_ff, pt_ff;

   // pre-rotate the left half plane by a quarter turn
   always_comb begin
      px    = DP_W'(in_x) <<< PRE_SHIFT;
      py    = DP_W'(in_y) <<< PRE_SHIFT;
      px_in = px;
      py_in = py;
      pa_in = '0;
      if (px < 0) begin
         if (py >= 0) begin
            pa_in = RIGHT;
            px_in = py;
            py_in = -px;
         end else begin
            pa_in = -RIGHT;
            px_in = -py;
            py_in = px;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= px_in;
         py_ff <= py_in;
         pa_ff <= pa_in;
         pt_ff <= in_tag;
      end
   end

   assign cx_w[0] = px_ff;
   assign cy_w[0] = py_ff;
   assign ca_w[0] = pa_ff;
   assign cv_w[0] = pv_ff;
   assign ct_w[0] = pt_ff;

   for (genvar i = 0; i < STEPS; i++) begin : g_stage
      localparam logic [63:0] ROM = atan_entry(i);
      localparam logic signed [ANG_W-1:0] STEP_ANG = ANG_W'(ROM);
      logic signed [DP_W-1:0]  x_ff, y_ff, dx, dy;
      logic signed [ANG_W-1:0] a_ff;
      logic                    v_ff, t_ff;

      assign dx = cy_w[i] >>> i;
      assign dy = cx_w[i] >>> i;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en) begin
            v_ff <= cv_w[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            t_ff <= ct_w[i];
            if (cy_w[i] > 0) begin
               x_ff <= cx_w[i] + dx;
               y_ff <= cy_w[i] - dy;
               a_ff <= ca_w[i] + STEP_ANG;
            end else begin
               x_ff <= cx_w[i] - dx;
               y_ff <= cy_w[i] + dy;
               a_ff <= ca_w[i] - STEP_ANG;
            end
         end
      end

      assign cx_w[i+1] = x_ff;
      assign cy_w[i+1] = y_ff;
      assign ca_w[i+1] = a_ff;
      assign cv_w[i+1] = v_ff;
      assign ct_w[i+1] = t_ff;
   end

   assign out_valid = cv_w[STEPS];
   assign out_angle = ca_w[STEPS];
   assign out_tag   = ct_w[STEPS];

endmodule

[rtl/ecef_to_geocentric_lat_lon.sv]
// Top level: ECEF position to geocentric latitude and longitude.
//
// Input stream (req_): one word per position, X, Y, Z in signed decimetres.
// Output stream (rsp_): one word per position, latitude and longitude in
// signed microdegrees, rounded half up; rsp_tuser flags the all-zero vector.
// Longitude is atan2(Y, X); latitude is atan2(Z, sqrt(X^2 + Y^2)), spherical.
//
// Throughput: one word per cycle while the receiver accepts. The pipeline is the
// 5-stage normalizer, the 32-stage square root, the pre-rotation plus one
// stage per CORDIC iteration, the rounding stage and the output register.
//
// Reset clears all valid bits; no words are in flight afterwards.
// When the receiver stalls, the output register holds its word and one more
// word lands in a skid register; only then does the pipeline freeze and
// req_tready drop. Nothing is lost or repeated across a stall.
module ecef_to_geocentric_lat_lon
   import ectg_pkg::*;
#(
   parameter int CORDIC_STEPS = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // pos_x[27:0], pos_y[55:28], pos_z[83:56], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // lat_udeg[27:0], lon_udeg[56:28], zero pad
   output logic [0:0]  rsp_tuser    // zero_vector
);

   logic en;

   logic            nv;
   logic [DP_W-1:0] ns2;
   sqrt_side_type   nside;

   logic             sv;
   logic [OPD_W-2:0] root;
   sqrt_side_type    sside;

   logic                    lat_v, lon_v, lat_zero, lon_xyzero;
   logic signed [ANG_W-1:0] lat_a, lon_a;

   // output register plus skid register
   logic                    out_v_ff, skid_v_ff;
   logic signed [LAT_W-1:0] out_lat_ff, skid_lat_ff;
   logic signed [LON_W-1:0] out_lon_ff, skid_lon_ff;
   logic                    out_zero_ff, skid_zero_ff;
   logic                    take;

   // pipeline runs while the skid register is free
   assign en         = !skid_v_ff;
   assign req_tready = en;

   ectg_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_x      (req_tdata[POS_W-1:0]),
      .in_y      (req_tdata[2*POS_W-1:POS_W]),
      .in_z      (req_tdata[3*POS_W-1:2*POS_W]),
      .out_valid (nv),
      .out_s2    (ns2),
      .out_side  (nside)
   );

   ectg_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (nv),
      .in_val    (ns2),
      .in_side   (nside),
      .out_valid (sv),
      .out_root  (root),
      .out_side  (sside)
   );

   // latitude: atan2(16 z, 16 rho)
   ectg_cordic #(.STEPS(CORDIC_STEPS)) u_lat (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sv),
      .in_x      ({1'b0, root}),
      .in_y      ({sside.z[POS_W-1], sside.z, 4'd0}),
      .in_tag    (sside.flags.zero),
      .out_valid (lat_v),
      .out_angle (lat_a),
      .out_tag   (lat_zero)
   );

   // longitude: atan2(16 y, 16 x)
   ectg_cordic #(.STEPS(CORDIC_STEPS)) u_lon (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sv),
      .in_x      ({sside.x[POS_W-1], sside.x, 4'd0}),
      .in_y      ({sside.y[POS_W-1], sside.y, 4'd0}),
      .in_tag    (sside.flags.xy_zero),
      .out_valid (lon_v),
      .out_angle (lon_a),
      .out_tag   (lon_xyzero)
   );

   // round half up to microdegrees, clamp, force the degenerate cases to zero
   localparam logic signed [ANG_W-1:0] HALF = ANG_W'(64'd1 << (ANG_FRAC - 1));

   logic signed [ANG_W-1:0] lat_sum, lon_sum;
   logic signed [RND_W-1:0] lat_r, lon_r, lat_c, lon_c;

   always_comb begin
      lat_sum = lat_a + HALF;
      lon_sum = lon_a + HALF;
      lat_r   = RND_W'(lat_sum >>> ANG_FRAC);
      lon_r   = RND_W'(lon_sum >>> ANG_FRAC);
      lat_c   = lat_r;
      if (lat_r > LAT_LIM) lat_c = LAT_LIM;
      if (lat_r < -LAT_LIM) lat_c = -LAT_LIM;
      if (lat_zero) lat_c = '0;
      lon_c = lon_r;
      if (lon_r > LON_LIM) lon_c = LON_LIM;
      if (lon_r < -LON_LIM) lon_c = -LON_LIM;
      if (lon_xyzero) lon_c = '0;
   end

   logic                    rv_ff;
   logic signed [LAT_W-1:0] rlat_ff;
   logic signed [LON_W-1:0] rlon_ff;
   logic                    rzero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (en) begin
         rv_ff <= lat_v && lon_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rlat_ff  <= lat_c[LAT_W-1:0];
         rlon_ff  <= lon_c[LON_W-1:0];
         rzero_ff <= lat_zero;
      end
   end

   assign take = rv_ff && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         out_v_ff  <= skid_v_ff || take;
         skid_v_ff <= 1'b0;
      end else if (take) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            out_lat_ff  <= skid_lat_ff;
            out_lon_ff  <= skid_lon_ff;
            out_zero_ff <= skid_zero_ff;
         end else begin
            out_lat_ff  <= rlat_ff;
            out_lon_ff  <= rlon_ff;
            out_zero_ff <= rzero_ff;
         end
      end else if (take) begin
         skid_lat_ff  <= rlat_ff;
         skid_lon_ff  <= rlon_ff;
         skid_zero_ff <= rzero_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {7'd0, out_lon_ff, out_lat_ff};
   assign rsp_tuser  = out_zero_ff;

endmodule
